// ----- hdl/rpfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfa_pkg: shared types and constants of the page frame allocator
// Item modes, result status codes, register map and configuration bundle.
// ----------------------------------------------------------------------------
package rpfa_pkg;

  // address and page geometry
  localparam int ADDR_W      = 32;
  localparam int PAGE_SHIFT  = 12;
  localparam int FRAME_NUM_W = ADDR_W - PAGE_SHIFT;

  // stream word layout
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int REF_OUT_W   = 16;
  localparam int OUT_TDATA_W = ADDR_W + REF_OUT_W;
  localparam int OUT_TUSER_W = 3;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_BASE       = 2'd0;
  localparam logic [1:0] REG_KERNEL_END = 2'd1;
  localparam logic [1:0] REG_TOP        = 2'd2;

  localparam logic [ADDR_W-1:0] BASE_RESET       = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] KERNEL_END_RESET = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] TOP_RESET        = 32'h8800_0000;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_ADDREF  = 2'd2,
    MODE_DROPREF = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE        = 2'd0,
    STAT_NO_MEM      = 2'd1,
    STAT_BAD_ADDR    = 2'd2,
    STAT_STACK_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic [ADDR_W-1:0] kernel_end;
    logic [ADDR_W-1:0] top_address;
  } cfg_regs_t;

endpackage

// ----- hdl/refcounted_page_frame_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_unit: page frame allocator top level
// LIFO free frame stack plus per-frame reference counts, stream in and out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per request; in_tuser is the mode (allocate, free,
//           add reference, drop reference), in_tdata the page address.
//   out_* : exactly one word per request, in request order.
//   cfg_* : base, kernel end and top address registers at 0x0, 0x4, 0x8;
//           write them only while no request is in flight.
// Timing: one request at a time. Rejected requests and empty-stack allocates
//   go from decode straight to the output state; free and reference requests
//   read the count first, and allocates that pop a frame read the stack, then
//   the count, as the count memory address comes from the stack memory. The
//   sequencer returns to idle as the result is loaded into the output register.
// Reset: the count table is swept to one, one entry per cycle, with in_tready
//   low throughout the sweep; configuration writes are taken meanwhile.
//   The free stack starts empty.
// Stall: a result waits in the output register while out_tready is low;
//   the next request is still taken and runs up to its own result.
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator_unit #(
  parameter int NUM_FRAMES  = 32768,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rpfa_pkg::IN_TDATA_W-1:0]      in_tdata,   // [31:0] page_address
  input  logic [rpfa_pkg::IN_TUSER_W-1:0]      in_tuser,   // [1:0] mode
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [rpfa_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [31:0] frame_address,
                                                           // [47:32] ref_count
  output logic [rpfa_pkg::OUT_TUSER_W-1:0]     out_tuser,  // [1:0] status, [2] released
  // configuration port
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [rpfa_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [rpfa_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [rpfa_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int FW = $clog2(NUM_FRAMES);

  rpfa_pkg::cfg_regs_t             cfg_regs;
  logic                            init_busy;
  rpfa_pkg::status_t               res_status;
  logic                            res_released;
  logic [rpfa_pkg::ADDR_W-1:0]     res_frame;
  logic [rpfa_pkg::REF_OUT_W-1:0]  res_count;

  logic                            stk_wr_en;
  logic [FW-1:0]                   stk_wr_addr;
  logic [FW-1:0]                   stk_wr_data;
  logic                            stk_rd_en;
  logic [FW-1:0]                   stk_rd_addr;
  logic [FW-1:0]                   stk_rd_data;

  logic                            cnt_wr_en;
  logic [FW-1:0]                   cnt_wr_addr;
  logic signed [COUNT_WIDTH-1:0]   cnt_wr_data;
  logic                            cnt_rd_en;
  logic [FW-1:0]                   cnt_rd_addr;
  logic signed [COUNT_WIDTH-1:0]   cnt_rd_data;

  // configuration registers
  rpfa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (cfg_regs)
  );

  // free frame stack
  rpfa_stack_ram #(
    .NUM_FRAMES (NUM_FRAMES),
    .FW         (FW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  // reference counts
  rpfa_count_ram #(
    .NUM_FRAMES  (NUM_FRAMES),
    .COUNT_WIDTH (COUNT_WIDTH),
    .FW          (FW)
  ) u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cnt_wr_en),
    .wr_addr   (cnt_wr_addr),
    .wr_data   (cnt_wr_data),
    .rd_en     (cnt_rd_en),
    .rd_addr   (cnt_rd_addr),
    .rd_data   (cnt_rd_data),
    .init_busy (init_busy)
  );

  // sequencer
  rpfa_ctrl #(
    .NUM_FRAMES  (NUM_FRAMES),
    .COUNT_WIDTH (COUNT_WIDTH),
    .FW          (FW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_regs),
    .init_busy    (init_busy),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_mode      (rpfa_pkg::mode_t'(in_tuser)),
    .in_addr      (in_tdata),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_frame    (res_frame),
    .out_status   (res_status),
    .out_released (res_released),
    .out_count    (res_count),
    .stk_wr_en    (stk_wr_en),
    .stk_wr_addr  (stk_wr_addr),
    .stk_wr_data  (stk_wr_data),
    .stk_rd_en    (stk_rd_en),
    .stk_rd_addr  (stk_rd_addr),
    .stk_rd_data  (stk_rd_data),
    .cnt_wr_en    (cnt_wr_en),
    .cnt_wr_addr  (cnt_wr_addr),
    .cnt_wr_data  (cnt_wr_data),
    .cnt_rd_en    (cnt_rd_en),
    .cnt_rd_addr  (cnt_rd_addr),
    .cnt_rd_data  (cnt_rd_data)
  );

  // result word packing
  assign out_tdata = {res_count, res_frame};
  assign out_tuser = {res_released, res_status};

  // no request taken while the count table is being swept
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !in_tready)
    else $error("request accepted during count table sweep");

  // one request at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request accepted while one is in flight");

  // a release only ever comes with a done status
  a_release_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_released) |-> (res_status == rpfa_pkg::STAT_DONE))
    else $error("released flag with a failing status");

  // an empty-stack allocate returns no frame and no count
  a_no_mem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (res_status == rpfa_pkg::STAT_NO_MEM)) |-> (out_tdata == '0))
    else $error("out-of-memory result carries a frame or count");

  // stack write only happens together with a count write
  a_push_with_count: assert property (@(posedge clk) disable iff (!rst_n)
    stk_wr_en |-> cnt_wr_en)
    else $error("stack push without count update");

endmodule

// ----- hdl/rpfa_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfa_cfg: configuration registers
// APB-style register file holding base, kernel end and top addresses.
// ----------------------------------------------------------------------------
module rpfa_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rpfa_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [rpfa_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [rpfa_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output rpfa_pkg::cfg_regs_t                 regs
);

  rpfa_pkg::cfg_regs_t regs_r;
  logic                wr_en;
  logic [1:0]          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.base_address <= rpfa_pkg::BASE_RESET;
      regs_r.kernel_end   <= rpfa_pkg::KERNEL_END_RESET;
      regs_r.top_address  <= rpfa_pkg::TOP_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        rpfa_pkg::REG_BASE:       regs_r.base_address <= pwdata;
        rpfa_pkg::REG_KERNEL_END: regs_r.kernel_end   <= pwdata;
        rpfa_pkg::REG_TOP:        regs_r.top_address  <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      rpfa_pkg::REG_BASE:       prdata = regs_r.base_address;
      rpfa_pkg::REG_KERNEL_END: prdata = regs_r.kernel_end;
      rpfa_pkg::REG_TOP:        prdata = regs_r.top_address;
      default:                  prdata = '0;
    endcase
  end

  assign regs = regs_r;

endmodule

// ----- hdl/rpfa_stack_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfa_stack_ram: free frame stack storage
// One write port, one read port, registered read data. Contents undefined
// until written; only entries below the stack depth are ever read.
// ----------------------------------------------------------------------------
module rpfa_stack_ram #(
  parameter int NUM_FRAMES = 32768,
  parameter int FW         = $clog2(NUM_FRAMES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [FW-1:0] wr_addr,
  input  logic [FW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [FW-1:0] rd_addr,
  output logic [FW-1:0] rd_data
);

  logic [FW-1:0] mem [NUM_FRAMES];
  logic [FW-1:0] rd_data_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/rpfa_count_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfa_count_ram: per-frame reference count table
// Registered-read memory; after reset a sweep writes one into every entry,
// one entry per cycle, while init_busy is high.
// ----------------------------------------------------------------------------
module rpfa_count_ram #(
  parameter int NUM_FRAMES  = 32768,
  parameter int COUNT_WIDTH = 16,
  parameter int FW          = $clog2(NUM_FRAMES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [FW-1:0]                 wr_addr,
  input  logic signed [COUNT_WIDTH-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [FW-1:0]                 rd_addr,
  output logic signed [COUNT_WIDTH-1:0] rd_data,
  output logic                          init_busy
);

  localparam logic signed [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
  localparam logic [FW-1:0]                 LAST    = FW'(NUM_FRAMES - 1);

  logic signed [COUNT_WIDTH-1:0] mem [NUM_FRAMES];
  logic signed [COUNT_WIDTH-1:0] rd_data_r;
  logic [FW-1:0]                 clr_addr_r;
  logic                          busy_r;

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      busy_r     <= 1'b1;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + FW'(1);
      if (clr_addr_r == LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= CNT_ONE;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data   = rd_data_r;
  assign init_busy = busy_r;

endmodule

// ----- hdl/rpfa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfa_ctrl: item sequencer
// Decodes an item, pops or pushes the free stack, does the count
// read-modify-write and holds the result in the output register.
// ----------------------------------------------------------------------------
module rpfa_ctrl #(
  parameter int NUM_FRAMES  = 32768,
  parameter int COUNT_WIDTH = 16,
  parameter int FW          = $clog2(NUM_FRAMES)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rpfa_pkg::cfg_regs_t                  cfg,
  input  logic                                 init_busy,
  // item input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rpfa_pkg::mode_t                      in_mode,
  input  logic [rpfa_pkg::ADDR_W-1:0]          in_addr,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rpfa_pkg::ADDR_W-1:0]          out_frame,
  output rpfa_pkg::status_t                    out_status,
  output logic                                 out_released,
  output logic [rpfa_pkg::REF_OUT_W-1:0]       out_count,
  // stack memory
  output logic                                 stk_wr_en,
  output logic [FW-1:0]                        stk_wr_addr,
  output logic [FW-1:0]                        stk_wr_data,
  output logic                                 stk_rd_en,
  output logic [FW-1:0]                        stk_rd_addr,
  input  logic [FW-1:0]                        stk_rd_data,
  // count memory
  output logic                                 cnt_wr_en,
  output logic [FW-1:0]                        cnt_wr_addr,
  output logic signed [COUNT_WIDTH-1:0]        cnt_wr_data,
  output logic                                 cnt_rd_en,
  output logic [FW-1:0]                        cnt_rd_addr,
  input  logic signed [COUNT_WIDTH-1:0]        cnt_rd_data
);

  localparam int AW  = rpfa_pkg::ADDR_W;
  localparam int FNW = rpfa_pkg::FRAME_NUM_W;
  localparam int DW  = $clog2(NUM_FRAMES + 1);
  localparam int CW  = COUNT_WIDTH;

  localparam logic [FNW:0]          FRAME_LIMIT = (FNW + 1)'(NUM_FRAMES);
  localparam logic [DW-1:0]         DEPTH_FULL  = DW'(NUM_FRAMES);
  localparam logic signed [CW-1:0]  CNT_ONE     = CW'(1);
  localparam logic signed [CW-1:0]  CNT_MAX     = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0]  CNT_MIN     = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_BUMP,
    S_OUT
  } state_t;

  state_t                      state_r, state_nxt;
  rpfa_pkg::mode_t             mode_r, mode_nxt;
  logic [AW-1:0]               addr_r, addr_nxt;
  logic [FW-1:0]               idx_r, idx_nxt;
  logic [DW-1:0]               depth_r, depth_nxt;
  logic [AW-1:0]               res_frame_r, res_frame_nxt;
  rpfa_pkg::status_t           res_status_r, res_status_nxt;
  logic                        res_rel_r, res_rel_nxt;
  logic [rpfa_pkg::REF_OUT_W-1:0] res_count_r, res_count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [AW-1:0]               out_frame_r, out_frame_nxt;
  rpfa_pkg::status_t           out_status_r, out_status_nxt;
  logic                        out_rel_r, out_rel_nxt;
  logic [rpfa_pkg::REF_OUT_W-1:0] out_count_r, out_count_nxt;

  logic [AW-1:0]               offset;
  logic [FNW-1:0]              frame_num;
  logic                        frame_ok;
  logic                        free_ok;
  logic                        count_up;
  logic signed [CW-1:0]        cnt_new;
  logic [DW-1:0]               depth_dec;

  // address checks on the captured item
  assign offset    = addr_r - cfg.base_address;
  assign frame_num = offset[AW-1:rpfa_pkg::PAGE_SHIFT];
  assign frame_ok  = (addr_r >= cfg.base_address) && ({1'b0, frame_num} < FRAME_LIMIT);
  assign free_ok   = (addr_r[rpfa_pkg::PAGE_SHIFT-1:0] == '0)
                  && (addr_r >= cfg.kernel_end)
                  && (addr_r < cfg.top_address)
                  && frame_ok;
  assign depth_dec = depth_r - DW'(1);

  // saturating count update
  assign count_up = (mode_r == rpfa_pkg::MODE_ALLOC) || (mode_r == rpfa_pkg::MODE_ADDREF);
  always_comb begin
    if (count_up) begin
      cnt_new = (cnt_rd_data == CNT_MAX) ? cnt_rd_data : cnt_rd_data + CNT_ONE;
    end else begin
      cnt_new = (cnt_rd_data == CNT_MIN) ? cnt_rd_data : cnt_rd_data - CNT_ONE;
    end
  end

  // next-state and memory request logic
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    addr_nxt       = addr_r;
    idx_nxt        = idx_r;
    depth_nxt      = depth_r;
    res_frame_nxt  = res_frame_r;
    res_status_nxt = res_status_r;
    res_rel_nxt    = res_rel_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_frame_nxt  = out_frame_r;
    out_status_nxt = out_status_r;
    out_rel_nxt    = out_rel_r;
    out_count_nxt  = out_count_r;

    stk_wr_en   = 1'b0;
    stk_wr_addr = depth_r[FW-1:0];
    stk_wr_data = idx_r;
    stk_rd_en   = 1'b0;
    stk_rd_addr = depth_dec[FW-1:0];
    cnt_wr_en   = 1'b0;
    cnt_wr_addr = idx_r;
    cnt_wr_data = cnt_new;
    cnt_rd_en   = 1'b0;
    cnt_rd_addr = frame_num[FW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          mode_nxt  = in_mode;
          addr_nxt  = in_addr;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        res_frame_nxt  = '0;
        res_status_nxt = rpfa_pkg::STAT_DONE;
        res_rel_nxt    = 1'b0;
        res_count_nxt  = '0;
        idx_nxt        = frame_num[FW-1:0];
        case (mode_r)
          rpfa_pkg::MODE_ALLOC: begin
            if (depth_r == '0) begin
              res_status_nxt = rpfa_pkg::STAT_NO_MEM;
              state_nxt      = S_OUT;
            end else begin
              depth_nxt = depth_dec;
              stk_rd_en = 1'b1;
              state_nxt = S_POP;
            end
          end
          rpfa_pkg::MODE_FREE: begin
            if (!free_ok) begin
              res_status_nxt = rpfa_pkg::STAT_BAD_ADDR;
              state_nxt      = S_OUT;
            end else begin
              cnt_rd_en = 1'b1;
              state_nxt = S_BUMP;
            end
          end
          default: begin
            if (!frame_ok) begin
              res_status_nxt = rpfa_pkg::STAT_BAD_ADDR;
              state_nxt      = S_OUT;
            end else begin
              cnt_rd_en = 1'b1;
              state_nxt = S_BUMP;
            end
          end
        endcase
      end

      // popped frame index is back from the stack
      S_POP: begin
        idx_nxt     = stk_rd_data;
        cnt_rd_en   = 1'b1;
        cnt_rd_addr = stk_rd_data;
        state_nxt   = S_BUMP;
      end

      // count is back: write it and push on release
      S_BUMP: begin
        cnt_wr_en     = 1'b1;
        res_count_nxt = rpfa_pkg::REF_OUT_W'(cnt_new);
        if (mode_r == rpfa_pkg::MODE_ALLOC) begin
          res_frame_nxt = cfg.base_address + (AW'(idx_r) << rpfa_pkg::PAGE_SHIFT);
        end
        if ((mode_r == rpfa_pkg::MODE_FREE) && (cnt_new[CW-1] || (cnt_new == '0))) begin
          if (depth_r == DEPTH_FULL) begin
            res_status_nxt = rpfa_pkg::STAT_STACK_FULL;
          end else begin
            stk_wr_en   = 1'b1;
            depth_nxt   = depth_r + DW'(1);
            res_rel_nxt = 1'b1;
          end
        end
        state_nxt = S_OUT;
      end

      // move the result into the output register once it is free
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_frame_nxt  = res_frame_r;
          out_status_nxt = res_status_r;
          out_rel_nxt    = res_rel_r;
          out_count_nxt  = res_count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    addr_r       <= addr_nxt;
    idx_r        <= idx_nxt;
    res_frame_r  <= res_frame_nxt;
    res_status_r <= res_status_nxt;
    res_rel_r    <= res_rel_nxt;
    res_count_r  <= res_count_nxt;
    out_frame_r  <= out_frame_nxt;
    out_status_r <= out_status_nxt;
    out_rel_r    <= out_rel_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_ready     = (state_r == S_IDLE) && !init_busy;
  assign out_valid    = out_valid_r;
  assign out_frame    = out_frame_r;
  assign out_status   = out_status_r;
  assign out_released = out_rel_r;
  assign out_count    = out_count_r;

endmodule

// ----- tb/refcounted_page_frame_allocator_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_unit_test: allocator stream testbench
// Drives allocate, free and reference words under several register settings.
// A frame ledger predicts every result, and each result word is checked
// field by field. Both sides idle at random, and the last part of the run
// goes with no idling on either side.
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator_unit_test;

  localparam int NUM_FRAMES     = 32768;
  localparam int COUNT_WIDTH    = 16;
  localparam int FRAME_IDX_W    = $clog2(NUM_FRAMES);
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int DRAIN_GAP      = 8;
  localparam int REPORT_CAP     = 60;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic signed [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

  logic                             clk         = 1'b0;
  logic                             rst_n       = 1'b0;
  logic                             in_tvalid   = 1'b0;
  logic                             in_tready;
  logic [rpfa_pkg::IN_TDATA_W-1:0]  in_tdata    = '0;  // [31:0] page_address
  logic [rpfa_pkg::IN_TUSER_W-1:0]  in_tuser    = '0;  // [1:0] mode
  logic                             out_tvalid;
  logic                             out_tready  = 1'b1;
  logic [rpfa_pkg::OUT_TDATA_W-1:0] out_tdata;   // [31:0] frame_address, [47:32] ref_count
  logic [rpfa_pkg::OUT_TUSER_W-1:0] out_tuser;   // [1:0] status, [2] released
  logic                             cfg_psel    = 1'b0;
  logic                             cfg_penable = 1'b0;
  logic                             cfg_pwrite  = 1'b0;
  logic [rpfa_pkg::CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [rpfa_pkg::CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [rpfa_pkg::CFG_DATA_W-1:0]  cfg_prdata;
  logic                             cfg_pready;

  bit idling_on   = 1'b0;
  bit tx_idle_en  = 1'b0;
  bit rx_stall_en = 1'b0;
  int stall_left  = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  refcounted_page_frame_allocator_unit #(
    .NUM_FRAMES (NUM_FRAMES),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // frame ledger: free stack, counts and registers as the block should hold them
  class frame_ledger;
    typedef struct {
      logic [rpfa_pkg::ADDR_W-1:0]   frame_address;
      rpfa_pkg::status_t             status;
      logic                          released;
      logic signed [COUNT_WIDTH-1:0] ref_count;
    } frame_result_t;

    logic [rpfa_pkg::ADDR_W-1:0]   base_address;
    logic [rpfa_pkg::ADDR_W-1:0]   kernel_end;
    logic [rpfa_pkg::ADDR_W-1:0]   top_address;
    logic [FRAME_IDX_W-1:0]        free_frames[NUM_FRAMES];
    int unsigned                   free_depth;
    logic signed [COUNT_WIDTH-1:0] ref_counts[NUM_FRAMES];
    frame_result_t                 awaited_results[$];
    int                            errors;

    function new();
      base_address = rpfa_pkg::BASE_RESET;
      kernel_end   = rpfa_pkg::KERNEL_END_RESET;
      top_address  = rpfa_pkg::TOP_RESET;
      free_depth   = 0;
      errors       = 0;
      foreach (ref_counts[i]) ref_counts[i] = COUNT_ONE;
    endfunction

    function void complain(string what);
      if (errors < REPORT_CAP) $error("%s", what);
      errors++;
    endfunction

    function void set_reg(logic [1:0] idx, logic [rpfa_pkg::ADDR_W-1:0] value);
      case (idx)
        rpfa_pkg::REG_BASE:       base_address = value;
        rpfa_pkg::REG_KERNEL_END: kernel_end   = value;
        rpfa_pkg::REG_TOP:        top_address  = value;
        default: ;
      endcase
    endfunction

    // frame index of an address, low page bits ignored
    function bit frame_hit(logic [rpfa_pkg::ADDR_W-1:0] addr,
                           output logic [FRAME_IDX_W-1:0] idx);
      logic [rpfa_pkg::ADDR_W-1:0] offset;
      idx = '0;
      if (addr < base_address) return 1'b0;
      offset = (addr - base_address) >> rpfa_pkg::PAGE_SHIFT;
      if (offset >= NUM_FRAMES) return 1'b0;
      idx = offset[FRAME_IDX_W-1:0];
      return 1'b1;
    endfunction

    // saturating count step
    function logic signed [COUNT_WIDTH-1:0] bump(logic [FRAME_IDX_W-1:0] idx, bit up);
      logic signed [COUNT_WIDTH-1:0] c;
      c = ref_counts[idx];
      if (up && c != COUNT_MAX) c = c + COUNT_ONE;
      else if (!up && c != COUNT_MIN) c = c - COUNT_ONE;
      ref_counts[idx] = c;
      return c;
    endfunction

    // predict the result of one accepted request word
    function void note_request(rpfa_pkg::mode_t mode, logic [rpfa_pkg::ADDR_W-1:0] addr);
      frame_result_t          r;
      logic [FRAME_IDX_W-1:0] idx;
      r.frame_address = '0;
      r.status        = rpfa_pkg::STAT_DONE;
      r.released      = 1'b0;
      r.ref_count     = '0;
      case (mode)
        rpfa_pkg::MODE_ALLOC: begin
          if (free_depth == 0) begin
            r.status = rpfa_pkg::STAT_NO_MEM;
          end else begin
            free_depth--;
            idx             = free_frames[free_depth];
            r.ref_count     = bump(idx, 1'b1);
            r.frame_address = base_address
                            + (rpfa_pkg::ADDR_W'(idx) << rpfa_pkg::PAGE_SHIFT);
          end
        end
        rpfa_pkg::MODE_FREE: begin
          if (addr[rpfa_pkg::PAGE_SHIFT-1:0] != '0 || addr < kernel_end
              || addr >= top_address || !frame_hit(addr, idx)) begin
            r.status = rpfa_pkg::STAT_BAD_ADDR;
          end else begin
            r.ref_count = bump(idx, 1'b0);
            if (r.ref_count <= 0) begin
              if (free_depth >= NUM_FRAMES) begin
                r.status = rpfa_pkg::STAT_STACK_FULL;
              end else begin
                free_frames[free_depth] = idx;
                free_depth++;
                r.released = 1'b1;
              end
            end
          end
        end
        default: begin
          if (!frame_hit(addr, idx)) r.status = rpfa_pkg::STAT_BAD_ADDR;
          else r.ref_count = bump(idx, mode == rpfa_pkg::MODE_ADDREF);
        end
      endcase
      awaited_results.push_back(r);
    endfunction

    // compare one result word with the oldest prediction
    function void check_result(logic [rpfa_pkg::OUT_TDATA_W-1:0] data,
                               logic [rpfa_pkg::OUT_TUSER_W-1:0] user);
      frame_result_t e;
      if (awaited_results.size() == 0) begin
        complain($sformatf("result word with nothing awaited: tdata %h tuser %h", data, user));
        return;
      end
      e = awaited_results.pop_front();
      if (data[rpfa_pkg::ADDR_W-1:0] !== e.frame_address)
        complain($sformatf("frame_address expected %h actual %h",
                           e.frame_address, data[rpfa_pkg::ADDR_W-1:0]));
      if (data[rpfa_pkg::ADDR_W +: rpfa_pkg::REF_OUT_W] !== e.ref_count)
        complain($sformatf("ref_count expected %0d actual %0d",
                           e.ref_count, $signed(data[rpfa_pkg::ADDR_W +: rpfa_pkg::REF_OUT_W])));
      if (user[1:0] !== e.status)
        complain($sformatf("status expected %0d actual %0d", e.status, user[1:0]));
      if (user[2] !== e.released)
        complain($sformatf("released expected %0d actual %0d", e.released, user[2]));
    endfunction
  endclass

  frame_ledger ledger;

  // result side: random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (rx_stall_en && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 14);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.check_result(out_tdata, out_tuser);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request word, called and returning at a falling edge
  task automatic send_word(rpfa_pkg::mode_t mode, logic [rpfa_pkg::ADDR_W-1:0] addr);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ledger.note_request(mode, addr);
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // hold off until every awaited result has arrived
  task automatic drain();
    in_tvalid <= 1'b0;
    while (ledger.awaited_results.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // register write, then read back where the register exists
  task automatic cfg_write(logic [1:0] idx, logic [rpfa_pkg::CFG_DATA_W-1:0] value);
    logic [rpfa_pkg::CFG_DATA_W-1:0] readback;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_penable <= 1'b0;
    if (idx == REG_UNUSED) begin
      cfg_psel <= 1'b0;
      @(negedge clk);
    end else begin
      ledger.set_reg(idx, value);
      cfg_pwrite <= 1'b0;
      @(negedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      readback = cfg_prdata;
      @(negedge clk);
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      if (readback !== value)
        ledger.complain($sformatf("register %0d expected %h actual %h", idx, value, readback));
    end
  endtask

  task automatic apply_config(logic [rpfa_pkg::ADDR_W-1:0] base,
                              logic [rpfa_pkg::ADDR_W-1:0] kend,
                              logic [rpfa_pkg::ADDR_W-1:0] top);
    cfg_write(rpfa_pkg::REG_BASE, base);
    cfg_write(rpfa_pkg::REG_KERNEL_END, kend);
    cfg_write(rpfa_pkg::REG_TOP, top);
  endtask

  // mostly frames from a small working set just above the kernel end, some noise
  function automatic void pick_request(output rpfa_pkg::mode_t mode,
                                       output logic [rpfa_pkg::ADDR_W-1:0] addr);
    logic [rpfa_pkg::ADDR_W-1:0] first;
    logic [rpfa_pkg::ADDR_W-1:0] idx;
    int                          roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      mode = rpfa_pkg::mode_t'($urandom_range(0, 3));
      addr = $urandom;
      return;
    end
    roll = $urandom_range(0, 99);
    mode = (roll < 30) ? rpfa_pkg::MODE_ALLOC : (roll < 60) ? rpfa_pkg::MODE_FREE :
           (roll < 80) ? rpfa_pkg::MODE_ADDREF : rpfa_pkg::MODE_DROPREF;
    first = '0;
    if (ledger.kernel_end > ledger.base_address)
      first = (ledger.kernel_end - ledger.base_address) >> rpfa_pkg::PAGE_SHIFT;
    if (first >= NUM_FRAMES - 16) first = '0;
    if ($urandom_range(0, 4) == 0) idx = $urandom_range(0, NUM_FRAMES - 1);
    else idx = first + $urandom_range(0, 15);
    addr = ledger.base_address + (idx << rpfa_pkg::PAGE_SHIFT);
    if ($urandom_range(0, 19) == 0)
      addr[rpfa_pkg::PAGE_SHIFT-1:0] = rpfa_pkg::PAGE_SHIFT'($urandom_range(1, 4095));
  endfunction

  task automatic run_traffic(int words);
    rpfa_pkg::mode_t             mode;
    logic [rpfa_pkg::ADDR_W-1:0] addr;
    for (int i = 0; i < words; i++) begin
      if (idling_on && i % 64 == 0) begin
        tx_idle_en  = $urandom_range(0, 2) != 0;
        rx_stall_en = $urandom_range(0, 2) != 0;
      end
      pick_request(mode, addr);
      send_word(mode, addr);
      if (tx_idle_en && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 14));
    end
  endtask

  initial begin
    logic [rpfa_pkg::ADDR_W-1:0] rbase;
    logic [rpfa_pkg::ADDR_W-1:0] rkend;
    ledger = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    // registers are taken while the count table is being cleared
    apply_config(rpfa_pkg::BASE_RESET, rpfa_pkg::KERNEL_END_RESET, rpfa_pkg::TOP_RESET);

    // directed words on the reset map
    send_word(rpfa_pkg::MODE_ALLOC,   32'h0000_0000);  // empty stack
    send_word(rpfa_pkg::MODE_FREE,    32'h8000_0000);  // first frame
    send_word(rpfa_pkg::MODE_FREE,    32'h8000_1000);
    send_word(rpfa_pkg::MODE_FREE,    32'h87FF_F000);  // last frame
    send_word(rpfa_pkg::MODE_FREE,    32'h8000_0800);  // misaligned
    send_word(rpfa_pkg::MODE_FREE,    32'h7FFF_F000);  // below kernel end
    send_word(rpfa_pkg::MODE_FREE,    32'h8800_0000);  // at top
    send_word(rpfa_pkg::MODE_FREE,    32'hFFFF_F000);
    send_word(rpfa_pkg::MODE_ADDREF,  32'h8000_1FFF);  // low bits ignored
    send_word(rpfa_pkg::MODE_DROPREF, 32'h8000_1000);
    send_word(rpfa_pkg::MODE_DROPREF, 32'h8000_1000);  // goes negative
    send_word(rpfa_pkg::MODE_ADDREF,  32'h7FFF_FFFF);  // below base
    send_word(rpfa_pkg::MODE_DROPREF, 32'h8800_0000);  // past the table
    send_word(rpfa_pkg::MODE_ADDREF,  32'h87FF_FFFF);
    send_word(rpfa_pkg::MODE_FREE,    32'h8000_0000);  // repeated free pushes again
    send_word(rpfa_pkg::MODE_FREE,    32'h8000_1000);
    repeat (5) send_word(rpfa_pkg::MODE_ALLOC, 32'hFFFF_FFFF);
    send_word(rpfa_pkg::MODE_ALLOC,   32'h0000_0000);  // empty again
    drain();

    // random phases over several register settings
    idling_on = 1'b1;
    run_traffic(150);
    drain();
    run_traffic(150);
    drain();
    apply_config(32'h0000_0000, 32'h0001_0000, 32'h0010_0000);
    run_traffic(300);
    drain();
    apply_config(32'hFFFF_F000, 32'h0000_0000, 32'hFFFF_FFFF);
    cfg_write(REG_UNUSED, 32'hDEAD_BEEF);
    run_traffic(150);
    drain();
    apply_config(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    run_traffic(100);
    drain();
    repeat (2) begin
      rbase = $urandom & 32'hFFFF_F000;
      rkend = rbase + ($urandom_range(0, 64) << rpfa_pkg::PAGE_SHIFT);
      apply_config(rbase, rkend, rkend + ($urandom_range(1, 2048) << rpfa_pkg::PAGE_SHIFT));
      run_traffic(150);
      drain();
    end

    // closing part with no idling on either side
    idling_on   = 1'b0;
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    apply_config(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    run_traffic(400);
    repeat (4) send_word(rpfa_pkg::MODE_ALLOC, 32'h0000_0000);
    drain();

    repeat (DRAIN_GAP) @(posedge clk);
    if (ledger.errors == 0 && ledger.awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
